### rtl/psu_pkg.sv
// Package: widths, codes, payload and shared-unit types for the plastic strain update block.
`default_nettype none
package psu_pkg;

	localparam int unsigned NUM_PARTICLES = 4096;
	localparam int unsigned ADDR_W = (NUM_PARTICLES > 1) ? $clog2(NUM_PARTICLES) : 1;

	localparam int unsigned IDX_W     = 12;
	localparam int unsigned DATA_W    = 32;
	localparam int unsigned LIM_W     = 31;
	localparam int unsigned NCOMP     = 6;
	localparam int unsigned WORD_W    = NCOMP * DATA_W + 1;
	localparam int unsigned CFG_IDX_W = 2;

	// shared unit widths
	localparam int unsigned OPW    = 36;
	localparam int unsigned WIDE   = 2 * OPW;
	localparam int unsigned DIVW   = OPW + 2;
	localparam int unsigned REMW   = OPW + 4;
	localparam int unsigned ITERS  = OPW;
	localparam int unsigned CNT_W  = $clog2(ITERS);

	// datapath widths
	localparam int unsigned DEV_W = 35;
	localparam int unsigned NV_W  = 36;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ELASTIC_LIMIT  = 2'd0,
		CFG_PLASTIC_LIMIT  = 2'd1,
		CFG_PLASTIC_ENABLE = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [IDX_W-1:0]         particle_index;
		logic signed [DATA_W-1:0] strain_xx;
		logic signed [DATA_W-1:0] strain_yy;
		logic signed [DATA_W-1:0] strain_zz;
		logic signed [DATA_W-1:0] strain_xy;
		logic signed [DATA_W-1:0] strain_xz;
		logic signed [DATA_W-1:0] strain_yz;
	} in_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] plastic_xx;
		logic signed [DATA_W-1:0] plastic_yy;
		logic signed [DATA_W-1:0] plastic_zz;
		logic signed [DATA_W-1:0] plastic_xy;
		logic signed [DATA_W-1:0] plastic_xz;
		logic signed [DATA_W-1:0] plastic_yz;
		logic                     fractured;
	} out_item_t;

	typedef enum logic [2:0] {
		ALU_MUL  = 3'b001,
		ALU_DIV  = 3'b010,
		ALU_SQRT = 3'b100
	} alu_op_t;

	typedef struct packed {
		logic            start;
		alu_op_t         op;
		logic [WIDE-1:0] a;
		logic [DIVW-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic            done;
		logic [WIDE-1:0] res;
	} alu_rsp_t;

	// saturate a wide signed value to the signed 32-bit range
	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [NV_W-1:0] v);
		logic signed [DATA_W-1:0] r;
		if (v[NV_W-1:DATA_W-1] == '0 || v[NV_W-1:DATA_W-1] == '1) begin
			r = v[DATA_W-1:0];
		end else if (v[NV_W-1]) begin
			r = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(DATA_W-1){1'b1}}};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

### rtl/psu_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module psu_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

### rtl/psu_alu.sv
// Shared arithmetic unit: registered multiply, bit-serial divide and square root.
`default_nettype none
module psu_alu
	import psu_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire alu_req_t req,
	output alu_rsp_t      rsp
);

	logic                busy_q;
	logic                done_q;
	logic [CNT_W-1:0]    cnt_q;
	alu_op_t             op_q;
	logic [REMW-1:0]     rem_q;
	logic [WIDE-1:0]     sh_q;
	logic [DIVW-1:0]     b_q;
	logic [OPW-1:0]      root_q;
	logic [WIDE-1:0]     res_q;

	logic [REMW-1:0]     trial;
	logic [REMW-1:0]     sub_op;
	logic                ge;
	logic [REMW-1:0]     diff;
	logic [OPW-1:0]      root_nx;

	// one step: bring down the next bits, compare, subtract
	always_comb begin
		if (op_q == ALU_DIV) begin
			trial  = {rem_q[REMW-2:0], sh_q[WIDE-1]};
			sub_op = REMW'(b_q);
		end else begin
			trial  = {rem_q[REMW-3:0], sh_q[WIDE-1:WIDE-2]};
			sub_op = REMW'({root_q, 2'b01});
		end
		ge      = (trial >= sub_op);
		diff    = trial - sub_op;
		root_nx = {root_q[OPW-2:0], ge};
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= ALU_MUL;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				op_q  <= req.op;
				cnt_q <= '0;
				if (req.op == ALU_MUL) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(ITERS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// operands, partial remainder and result
	always_ff @(posedge clk) begin
		if (req.start) begin
			b_q    <= req.b;
			root_q <= '0;
			if (req.op == ALU_MUL) begin
				res_q <= WIDE'(req.a[OPW-1:0]) * WIDE'(req.b[OPW-1:0]);
			end
			if (req.op == ALU_DIV) begin
				rem_q <= REMW'(req.a[WIDE-1:OPW]);
				sh_q  <= {req.a[OPW-1:0], {OPW{1'b0}}};
			end else begin
				rem_q <= '0;
				sh_q  <= req.a;
			end
		end else if (busy_q) begin
			rem_q  <= ge ? diff : trial;
			sh_q   <= (op_q == ALU_DIV) ? {sh_q[WIDE-2:0], 1'b0} : {sh_q[WIDE-3:0], 2'b00};
			root_q <= root_nx;
			if (cnt_q == CNT_W'(ITERS - 1)) begin
				res_q <= WIDE'(root_nx);
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.res  = res_q;

endmodule
`default_nettype wire

### rtl/plastic_strain_update.sv
// Top level: sequencer, particle store and configuration registers of the plastic strain update.
`default_nettype none
// Takes one strain beat at a time for one particle and returns one result beat with the
// particle's stored plastic strain and fracture flag after the update. After reset the
// particle store is cleared one entry per cycle, all NUM_PARTICLES (4096) entries;
// item_stall stays high meanwhile, configuration writes are taken throughout. How long an
// item takes depends on its path: plasticity off, a deviation within the elastic limit, a
// yield, or a yield that fractures. It is set by the shared arithmetic unit, which works
// out every divide or square root one quotient or root bit per cycle, with six divides per
// scaling pass. A new item is taken as soon as the previous result sits in the output
// register.
module plastic_strain_update
	import psu_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 item_valid,
	output logic                      item_stall,
	input  wire in_item_t             item,
	output logic                      result_valid,
	input  wire logic                 result_stall,
	output out_item_t                 result,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [DATA_W-1:0]    cfg_data
);

	typedef enum logic [13:0] {
		S_CLEAR = 14'b00000000000001,
		S_IDLE  = 14'b00000000000010,
		S_READ  = 14'b00000000000100,
		S_SQD   = 14'b00000000001000,
		S_EL    = 14'b00000000010000,
		S_SQRT1 = 14'b00000000100000,
		S_MUL1  = 14'b00000001000000,
		S_DIV1  = 14'b00000010000000,
		S_SQN   = 14'b00000100000000,
		S_PL    = 14'b00001000000000,
		S_SQRT2 = 14'b00010000000000,
		S_MUL2  = 14'b00100000000000,
		S_DIV2  = 14'b01000000000000,
		S_DONE  = 14'b10000000000000
	} state_t;

	state_t                     state_q;
	logic                       wait_q;
	logic [2:0]                 k_q;
	logic                       upd_q;
	logic [ADDR_W-1:0]          clr_q;
	logic [LIM_W-1:0]           el_q;
	logic [LIM_W-1:0]           pl_q;
	logic                       en_q;
	logic                       result_valid_q;
	out_item_t                  result_q;

	logic [IDX_W-1:0]           idx_q;
	logic signed [DEV_W-1:0]    d_q  [NCOMP];
	logic signed [DATA_W-1:0]   st_q [NCOMP];
	logic signed [NV_W-1:0]     nv_q [NCOMP];
	logic                       frac_q;
	logic [WIDE-1:0]            acc_q;
	logic [OPW-1:0]             n_q;
	logic [OPW-1:0]             m_q;

	alu_req_t                   req;
	alu_rsp_t                   rsp;

	logic signed [DATA_W-1:0]   s_in [NCOMP];
	logic signed [DEV_W-1:0]    d_in [NCOMP];
	logic signed [DEV_W-1:0]    tr;
	logic [LIM_W+1:0]           e3;
	logic [OPW:0]               n3;
	logic signed [DEV_W-1:0]    dsel;
	logic [OPW-1:0]             dmag;
	logic signed [NV_W-1:0]     nvsel;
	logic [OPW-1:0]             nmag;
	logic signed [NV_W-1:0]     q_s;
	logic signed [NV_W-1:0]     nv_new;
	logic signed [NV_W-1:0]     om_s;
	logic                       op_done;
	logic                       accept;
	logic                       go;
	logic                       in_range;
	logic                       over;

	logic                       ram_we;
	logic [ADDR_W-1:0]          ram_waddr;
	logic [WORD_W-1:0]          ram_wdata;
	logic [WORD_W-1:0]          ram_rdata;
	logic signed [DATA_W-1:0]   rd_st [NCOMP];
	logic signed [DATA_W-1:0]   sat_nv [NCOMP];

	assign cfg_ready    = 1'b1;
	assign item_stall   = (state_q != S_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	assign accept   = item_valid && (state_q == S_IDLE);
	assign op_done  = wait_q && rsp.done;
	assign go       = (state_q == S_DONE) && (!result_valid_q || !result_stall);
	assign in_range = (32'(idx_q) < NUM_PARTICLES);
	assign over     = (acc_q > rsp.res);

	// three times the deviatoric strain of the incoming beat
	always_comb begin
		s_in[0] = item.strain_xx;
		s_in[1] = item.strain_yy;
		s_in[2] = item.strain_zz;
		s_in[3] = item.strain_xy;
		s_in[4] = item.strain_xz;
		s_in[5] = item.strain_yz;
		tr = DEV_W'(s_in[0]) + DEV_W'(s_in[1]) + DEV_W'(s_in[2]);
		for (int i = 0; i < NCOMP; i++) begin
			d_in[i] = (DEV_W'(s_in[i]) <<< 1) + DEV_W'(s_in[i]) - ((i < 3) ? tr : '0);
		end
	end

	// lane selection, magnitudes and signed quotients
	always_comb begin
		e3    = {1'b0, el_q, 1'b0} + (LIM_W+2)'(el_q);
		n3    = {n_q, 1'b0} + (OPW+1)'(n_q);
		dsel  = d_q[k_q];
		dmag  = dsel[DEV_W-1] ? OPW'(unsigned'(-dsel)) : OPW'(unsigned'(dsel));
		nvsel = nv_q[k_q];
		nmag  = nvsel[NV_W-1] ? unsigned'(-nvsel) : unsigned'(nvsel);
		q_s   = signed'({1'b0, rsp.res[NV_W-2:0]});
		nv_new = NV_W'(st_q[k_q]) + (dsel[DEV_W-1] ? -q_s : q_s);
		om_s  = nvsel[NV_W-1] ? -q_s : q_s;
		for (int i = 0; i < NCOMP; i++) begin
			sat_nv[i] = sat32(nv_q[i]);
		end
	end

	// drive the shared unit from the current step
	always_comb begin
		req.start = 1'b0;
		req.op    = ALU_MUL;
		req.a     = '0;
		req.b     = '0;
		unique case (state_q)
			S_SQD: begin
				req.a = WIDE'(dmag);
				req.b = DIVW'(dmag);
			end
			S_EL: begin
				req.a = WIDE'(e3);
				req.b = DIVW'(e3);
			end
			S_SQRT1, S_SQRT2: begin
				req.op = ALU_SQRT;
				req.a  = acc_q;
			end
			S_MUL1: begin
				req.a = WIDE'(dmag);
				req.b = DIVW'(n_q - OPW'(e3));
			end
			S_DIV1: begin
				req.op = ALU_DIV;
				req.a  = {rsp.res[WIDE-2:0], 1'b0} + WIDE'(n3);
				req.b  = DIVW'({n3, 1'b0});
			end
			S_SQN: begin
				req.a = WIDE'(nmag);
				req.b = DIVW'(nmag);
			end
			S_PL: begin
				req.a = WIDE'(pl_q);
				req.b = DIVW'(pl_q);
			end
			S_MUL2: begin
				req.a = WIDE'(nmag);
				req.b = DIVW'(pl_q);
			end
			S_DIV2: begin
				req.op = ALU_DIV;
				req.a  = {rsp.res[WIDE-2:0], 1'b0} + WIDE'(m_q);
				req.b  = DIVW'({m_q, 1'b0});
			end
			default: begin
				req.op = ALU_MUL;
			end
		endcase
		if (state_q != S_CLEAR && state_q != S_IDLE && state_q != S_READ &&
		    state_q != S_DONE) begin
			req.start = !wait_q;
		end
	end

	psu_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// store word: fracture flag on top, then the six components
	always_comb begin
		for (int i = 0; i < NCOMP; i++) begin
			rd_st[i] = ram_rdata[DATA_W*(NCOMP-1-i) +: DATA_W];
		end
		ram_wdata = '0;
		if (state_q != S_CLEAR) begin
			ram_wdata[WORD_W-1] = frac_q;
			for (int i = 0; i < NCOMP; i++) begin
				ram_wdata[DATA_W*(NCOMP-1-i) +: DATA_W] = st_q[i];
			end
		end
		ram_we    = (state_q == S_CLEAR) || (go && upd_q);
		ram_waddr = (state_q == S_CLEAR) ? clr_q : ADDR_W'(idx_q);
	end

	psu_ram #(
		.WIDTH (WORD_W),
		.DEPTH (NUM_PARTICLES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ADDR_W'(item.particle_index)),
		.rdata (ram_rdata)
	);

	// sequencer, configuration and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLEAR;
			wait_q         <= 1'b0;
			k_q            <= '0;
			upd_q          <= 1'b0;
			clr_q          <= '0;
			el_q           <= LIM_W'(16777);
			pl_q           <= LIM_W'(8153727);
			en_q           <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_ELASTIC_LIMIT:  el_q <= cfg_data[LIM_W-1:0];
					CFG_PLASTIC_LIMIT:  pl_q <= cfg_data[LIM_W-1:0];
					CFG_PLASTIC_ENABLE: en_q <= cfg_data[0];
					default:            en_q <= en_q;
				endcase
			end

			// drop the result beat once taken, unless a new one replaces it
			if (result_valid_q && !result_stall && !go) begin
				result_valid_q <= 1'b0;
			end

			// hold the issue flag until the shared unit answers
			if (req.start) begin
				wait_q <= 1'b1;
			end else if (op_done) begin
				wait_q <= 1'b0;
			end

			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(NUM_PARTICLES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (item_valid) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					upd_q <= 1'b0;
					k_q   <= '0;
					state_q <= (en_q && in_range) ? S_SQD : S_DONE;
				end
				S_SQD: begin
					if (op_done) begin
						k_q <= (k_q == 3'(NCOMP - 1)) ? '0 : k_q + 1'b1;
						if (k_q == 3'(NCOMP - 1)) begin
							state_q <= S_EL;
						end
					end
				end
				S_EL: begin
					if (op_done) begin
						state_q <= over ? S_SQRT1 : S_DONE;
					end
				end
				S_SQRT1: begin
					if (op_done) begin
						state_q <= S_MUL1;
					end
				end
				S_MUL1: begin
					if (op_done) begin
						state_q <= S_DIV1;
					end
				end
				S_DIV1: begin
					if (op_done) begin
						k_q <= (k_q == 3'(NCOMP - 1)) ? '0 : k_q + 1'b1;
						state_q <= (k_q == 3'(NCOMP - 1)) ? S_SQN : S_MUL1;
					end
				end
				S_SQN: begin
					if (op_done) begin
						k_q <= (k_q == 3'(NCOMP - 1)) ? '0 : k_q + 1'b1;
						if (k_q == 3'(NCOMP - 1)) begin
							state_q <= S_PL;
						end
					end
				end
				S_PL: begin
					if (op_done) begin
						upd_q   <= 1'b1;
						state_q <= over ? S_SQRT2 : S_DONE;
					end
				end
				S_SQRT2: begin
					if (op_done) begin
						state_q <= S_MUL2;
					end
				end
				S_MUL2: begin
					if (op_done) begin
						state_q <= S_DIV2;
					end
				end
				S_DIV2: begin
					if (op_done) begin
						k_q <= (k_q == 3'(NCOMP - 1)) ? '0 : k_q + 1'b1;
						state_q <= (k_q == 3'(NCOMP - 1)) ? S_DONE : S_MUL2;
					end
				end
				S_DONE: begin
					if (go) begin
						result_valid_q <= 1'b1;
						state_q        <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q <= item.particle_index;
			acc_q <= '0;
			for (int i = 0; i < NCOMP; i++) begin
				d_q[i] <= d_in[i];
			end
		end
		if (state_q == S_READ) begin
			frac_q <= in_range ? ram_rdata[WORD_W-1] : 1'b0;
			for (int i = 0; i < NCOMP; i++) begin
				st_q[i] <= in_range ? rd_st[i] : '0;
			end
		end
		if (op_done) begin
			unique case (state_q)
				S_SQD, S_SQN: acc_q <= acc_q + rsp.res;
				S_SQRT1:      n_q   <= rsp.res[OPW-1:0];
				S_SQRT2:      m_q   <= rsp.res[OPW-1:0];
				S_DIV1: begin
					nv_q[k_q] <= nv_new;
					if (k_q == 3'(NCOMP - 1)) begin
						acc_q <= '0;
					end
				end
				S_PL: begin
					if (!over) begin
						frac_q <= 1'b0;
						for (int i = 0; i < NCOMP; i++) begin
							st_q[i] <= sat_nv[i];
						end
					end
				end
				S_DIV2: begin
					st_q[k_q] <= sat32(om_s);
					frac_q    <= 1'b1;
				end
				default: begin
					acc_q <= acc_q;
				end
			endcase
		end
		if (go) begin
			result_q.plastic_xx <= st_q[0];
			result_q.plastic_yy <= st_q[1];
			result_q.plastic_zz <= st_q[2];
			result_q.plastic_xy <= st_q[3];
			result_q.plastic_xz <= st_q[4];
			result_q.plastic_yz <= st_q[5];
			result_q.fractured  <= frac_q;
		end
	end

endmodule
`default_nettype wire

### rtl/psu_chk.sv
// Port checker for the plastic strain update, bound to the top level.
`default_nettype none
module psu_chk
	import psu_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 item_valid,
	input wire logic                 item_stall,
	input wire in_item_t             item,
	input wire logic                 result_valid,
	input wire logic                 result_stall,
	input wire out_item_t            result,
	input wire logic                 cfg_valid,
	input wire logic                 cfg_ready,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [DATA_W-1:0]    cfg_data
);

	// a stalled result beat holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result beat changed while stalled");

	// one item at a time: stall right after an accepted beat
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("second item taken while one is in work");

	// no result can appear the cycle after an item is taken
	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> !$rose(result_valid))
		else $error("result appeared too early");

	// a new result comes with the input side open again
	a_ready_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> !item_stall)
		else $error("input still stalled after result was produced");

endmodule

bind plastic_strain_update psu_chk u_chk (.*);
`default_nettype wire
